>>> src/blb_pkg.sv
// Shared types, constants and the voltage ladder table for the LED bargraph block.
`timescale 1ns / 1ps

package blb_pkg;

    localparam int LED_COUNT = 16;
    localparam logic [LED_COUNT-1:0] ALL_LEDS = '1;
    localparam logic [LED_COUNT-1:0] BAR5 = 16'h1FF8;
    localparam int LADDER_N = 16;

    // Low-voltage alert bands and their blink timing.
    localparam logic [15:0] FAST_BAND_MV = 16'd3200;
    localparam logic [7:0] SLOW_ON_TICKS = 8'd10;
    localparam logic [7:0] SLOW_LAST_TICK = 8'd19;
    localparam logic [7:0] FAST_ON_TICKS = 8'd2;
    localparam logic [7:0] FAST_LAST_TICK = 8'd3;

    // Lap-energy blink timing.
    localparam logic [7:0] ENERGY_ON_TICKS = 8'd5;
    localparam logic [7:0] ENERGY_LAST_TICK = 8'd10;
    localparam logic [2:0] ENERGY_PERIODS = 3'd5;

    // Configuration register reset values.
    localparam logic [7:0] HB_TIMEOUT_RESET = 8'd25;
    localparam logic [7:0] ENERGY_HIGH_RESET = 8'd105;
    localparam logic [7:0] ENERGY_LOW_RESET = 8'd95;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_HB_TIMEOUT  = 2'd0,
        CFG_ENERGY_HIGH = 2'd1,
        CFG_ENERGY_LOW  = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        COL_RED   = 2'd0,
        COL_GREEN = 2'd1,
        COL_BLUE  = 2'd2
    } t_colour;

    typedef struct packed {
        logic [LED_COUNT-1:0] red;
        logic [LED_COUNT-1:0] green;
        logic [LED_COUNT-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [15:0]          above;
        t_colour              colour;
        logic [LED_COUNT-1:0] mask;
    } t_rung;

    // Highest rung first; the first threshold exceeded picks the bar.
    localparam t_rung LADDER [LADDER_N] = '{
        '{16'd4000, COL_GREEN, 16'h1FF8}, '{16'd3950, COL_GREEN, 16'h0FF0},
        '{16'd3900, COL_GREEN, 16'h07E0}, '{16'd3850, COL_GREEN, 16'h03C0},
        '{16'd3800, COL_GREEN, 16'h0180},
        '{16'd3750, COL_BLUE,  16'h1FF8}, '{16'd3700, COL_BLUE,  16'h0FF0},
        '{16'd3650, COL_BLUE,  16'h07E0}, '{16'd3600, COL_BLUE,  16'h03C0},
        '{16'd3550, COL_BLUE,  16'h0180},
        '{16'd3500, COL_RED,   16'h1008}, '{16'd3450, COL_RED,   16'h1818},
        '{16'd3400, COL_RED,   16'h1C38}, '{16'd3350, COL_RED,   16'h1E78},
        '{16'd3300, COL_RED,   16'h1FF8}, '{16'd3250, COL_RED,   16'h1FF8}
    };

endpackage

>>> src/blb_if.sv
// Valid/ready channel interfaces for tick requests and LED mask results.
`timescale 1ns / 1ps

interface blb_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  heartbeat_byte;
    logic [15:0] cell_voltage;
    logic        energy_update;
    logic [7:0]  energy_value;

    modport source (output valid, heartbeat_byte, cell_voltage, energy_update,
                    energy_value, input ready);
    modport sink (input valid, heartbeat_byte, cell_voltage, energy_update,
                  energy_value, output ready);
endinterface

interface blb_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] red_mask;
    logic [15:0] green_mask;
    logic [15:0] blue_mask;

    modport source (output valid, red_mask, green_mask, blue_mask, input ready);
    modport sink (input valid, red_mask, green_mask, blue_mask, output ready);
endinterface

>>> src/blb_battery.sv
// Heartbeat watchdog, voltage ladder and low-voltage alert blinker.
`timescale 1ns / 1ps

module blb_battery import blb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_adv,
    input  logic [7:0]  i_heartbeat,
    input  logic [15:0] i_mv,
    input  logic [7:0]  i_timeout,
    output t_rgb        o_rgb
);

    logic [7:0]  r_last_hb;
    logic [15:0] r_stale;
    logic [7:0]  r_alert;
    logic [15:0] n_stale;
    logic [7:0]  n_alert;

    // Saturating count of ticks with an unchanged heartbeat.
    always_comb begin
        if (i_heartbeat == r_last_hb) begin
            n_stale = (r_stale == 16'hFFFF) ? r_stale : r_stale + 16'd1;
        end else begin
            n_stale = '0;
        end
    end

    // Ladder search, then the blinking red bar below the lowest rung; all dark once the heartbeat is stale.
    always_comb begin
        logic       found;
        logic [7:0] alert;
        found = 1'b0;
        alert = r_alert;
        o_rgb = '0;
        if (n_stale < {8'd0, i_timeout}) begin
            // Walk upward so the highest exceeded rung wins.
            for (int i = LADDER_N - 1; i >= 0; i--) begin
                if (i_mv > LADDER[i].above) begin
                    found = 1'b1;
                    o_rgb = '0;
                    case (LADDER[i].colour)
                        COL_RED:   o_rgb.red = LADDER[i].mask;
                        COL_GREEN: o_rgb.green = LADDER[i].mask;
                        COL_BLUE:  o_rgb.blue = LADDER[i].mask;
                        default:   o_rgb = '0;
                    endcase
                end
            end
            if (!found) begin
                if (i_mv > FAST_BAND_MV) begin
                    if (r_alert < SLOW_ON_TICKS) begin
                        o_rgb.red = BAR5;
                    end else if (r_alert > SLOW_LAST_TICK) begin
                        alert = '0;
                    end
                end else begin
                    if (r_alert < FAST_ON_TICKS) begin
                        o_rgb.red = BAR5;
                    end else if (r_alert > FAST_LAST_TICK) begin
                        alert = '0;
                    end
                end
            end
        end
        n_alert = alert + 8'd1;
    end

    // State advances once per processed tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_hb <= '0;
            r_stale   <= '0;
            r_alert   <= '0;
        end else if (i_adv) begin
            r_last_hb <= i_heartbeat;
            r_stale   <= n_stale;
            r_alert   <= n_alert;
        end
    end

endmodule

>>> src/blb_energy.sv
// Lap-energy blink sequence that overrides the battery bar.
`timescale 1ns / 1ps

module blb_energy import blb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_adv,
    input  logic       i_update,
    input  logic [7:0] i_value,
    input  logic [7:0] i_high_limit,
    input  logic [7:0] i_low_limit,
    input  t_rgb       i_rgb,
    output t_rgb       o_rgb
);

    logic [7:0] r_received;
    logic [7:0] r_shown;
    logic       r_awaiting;
    logic [7:0] r_count;
    logic [2:0] r_periods;
    logic [7:0] n_received;
    logic [7:0] n_shown;
    logic       n_awaiting;
    logic [7:0] n_count;
    logic [2:0] n_periods;

    // Start, run and finish the five-period blink of the lap colour.
    always_comb begin
        logic [7:0] count;
        n_received = i_update ? i_value : r_received;
        n_shown    = r_shown;
        n_awaiting = r_awaiting;
        n_periods  = r_periods;
        count      = r_count;
        o_rgb      = i_rgb;
        if ((n_shown != n_received) && n_awaiting) begin
            n_shown    = n_received;
            n_awaiting = 1'b0;
        end
        if ((n_shown == n_received) && !n_awaiting) begin
            o_rgb = '0;
            if (count < ENERGY_ON_TICKS) begin
                if (n_shown > i_high_limit) begin
                    o_rgb.red = ALL_LEDS;
                end else if (n_shown < i_low_limit) begin
                    o_rgb.green = ALL_LEDS;
                end else begin
                    o_rgb.blue = ALL_LEDS;
                end
            end else if (count > ENERGY_LAST_TICK) begin
                n_periods = n_periods + 3'd1;
                count     = '0;
            end
            if (n_periods >= ENERGY_PERIODS) begin
                n_periods  = '0;
                n_awaiting = 1'b1;
                n_shown    = '0;
                n_received = '0;
            end
        end
        n_count = count + 8'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_received <= '0;
            r_shown    <= '0;
            r_awaiting <= 1'b1;
            r_count    <= '0;
            r_periods  <= '0;
        end else if (i_adv) begin
            r_received <= n_received;
            r_shown    <= n_shown;
            r_awaiting <= n_awaiting;
            r_count    <= n_count;
            r_periods  <= n_periods;
        end
    end

endmodule

>>> src/battery_led_bargraph_top.sv
// Top level of the battery LED bargraph: registers, handshake and result stage.
`timescale 1ns / 1ps

// Each display tick request carries a heartbeat byte, the lowest cell voltage
// in mV and an optional lap-energy byte, and yields one result with red, green
// and blue 16-bit LED masks. A request is captured in an input register when it
// is accepted, the watchdog, voltage ladder and lap-energy blink logic work on
// it while it is held there, and the masks land in an output register once the
// result register can take them. The result holds until the output side takes
// it. One request is taken every clock cycle while the output side is ready.
// The user must write the three 8-bit configuration registers through the
// plain write port only while the block is idle; the block does not check it.

module battery_led_bargraph_top import blb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    blb_in_if.sink     i_in,
    blb_out_if.source  o_out
);

    logic [7:0]  r_timeout;
    logic [7:0]  r_high_limit;
    logic [7:0]  r_low_limit;
    logic        r_in_valid;
    logic [7:0]  r_heartbeat;
    logic [15:0] r_mv;
    logic        r_update;
    logic [7:0]  r_value;
    logic        r_out_valid;
    t_rgb        r_rgb;
    logic        w_adv;
    t_rgb        w_batt_rgb;
    t_rgb        w_final_rgb;

    // Configuration registers; indexes past the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout    <= HB_TIMEOUT_RESET;
            r_high_limit <= ENERGY_HIGH_RESET;
            r_low_limit  <= ENERGY_LOW_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HB_TIMEOUT:  r_timeout <= i_cfg_data;
                CFG_ENERGY_HIGH: r_high_limit <= i_cfg_data;
                CFG_ENERGY_LOW:  r_low_limit <= i_cfg_data;
                default:         r_timeout <= r_timeout;
            endcase
        end
    end

    // The held request is processed when the result register can take it.
    assign w_adv = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_adv;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_heartbeat <= i_in.heartbeat_byte;
            r_mv        <= i_in.cell_voltage;
            r_update    <= i_in.energy_update;
            r_value     <= i_in.energy_value;
        end
    end

    blb_battery u_battery (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (w_adv),
        .i_heartbeat (r_heartbeat),
        .i_mv        (r_mv),
        .i_timeout   (r_timeout),
        .o_rgb       (w_batt_rgb)
    );

    blb_energy u_energy (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (w_adv),
        .i_update     (r_update),
        .i_value      (r_value),
        .i_high_limit (r_high_limit),
        .i_low_limit  (r_low_limit),
        .i_rgb        (w_batt_rgb),
        .o_rgb        (w_final_rgb)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rgb <= w_final_rgb;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.red_mask   = r_rgb.red;
    assign o_out.green_mask = r_rgb.green;
    assign o_out.blue_mask  = r_rgb.blue;

endmodule
